// ===== design/zsb_pkg.sv =====
// Shared codes, constants and types for the zoomed sprite blitter.
package zsb_pkg;

    // Register index codes on the configuration port
    localparam int REG_IDX_BITS = 3;
    localparam logic [REG_IDX_BITS-1:0] REG_DISPLAY_WIDTH  = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_DISPLAY_HEIGHT = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_OFFSET_X       = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_OFFSET_Y       = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_ZOOM           = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_IMAGE_WIDTH    = 3'd5;
    localparam logic [REG_IDX_BITS-1:0] REG_IMAGE_HEIGHT   = 3'd6;
    localparam logic [REG_IDX_BITS-1:0] REG_ADAPTER_MODE   = 3'd7;

    // Adapter mode codes
    localparam logic [1:0] MODE_OTHER = 2'd0;
    localparam logic [1:0] MODE_MDA   = 2'd1;
    localparam logic [1:0] MODE_LORES = 2'd2;

    // Zoom saturates at this code
    localparam logic [1:0] ZOOM_MAX = 2'd2;

    // Register reset values
    localparam int DISPLAY_WIDTH_RST  = 640;
    localparam int DISPLAY_HEIGHT_RST = 400;
    localparam int IMAGE_DIM_RST      = 64;

    // Replication exponents: x up to 4 (low-res doubling), y up to 2
    localparam int ZX_BITS   = 3;
    localparam int ZY_BITS   = 2;
    localparam int SX_BITS   = 4;
    localparam int SY_BITS   = 2;
    localparam int ZOOM_BITS = ZX_BITS + ZY_BITS;

    // Depth of the job queue between front and back end
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [ZX_BITS-1:0] zx;
        logic [ZY_BITS-1:0] zy;
    } t_zoom;

endpackage

// ===== design/zsb_front.sv =====
// Front end: configuration registers, origin arithmetic, pixel classification.
module zsb_front #(
    parameter int COORD_BITS     = 10,
    parameter int IMAGE_DIM_BITS = 8,
    localparam int CFG_W = (COORD_BITS > IMAGE_DIM_BITS) ? COORD_BITS : IMAGE_DIM_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [zsb_pkg::REG_IDX_BITS-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]                i_cfg_data,
    input  logic                            i_push,
    input  logic [7:0]                      i_pixel_color,
    input  logic                            i_q_full,
    output logic                            o_full,
    output logic                            o_q_push,
    output logic [COORD_BITS-1:0]           o_bx,
    output logic [COORD_BITS-1:0]           o_by,
    output zsb_pkg::t_zoom                  o_zoom,
    output logic [7:0]                      o_color
);
    import zsb_pkg::*;

    // Signed working width: covers offset minus half image, scaled by up to 16, plus a display half
    localparam int SW = CFG_W + 8;

    logic        [COORD_BITS-1:0]     r_disp_w;
    logic        [COORD_BITS-1:0]     r_disp_h;
    logic signed [COORD_BITS-1:0]     r_off_x;
    logic signed [COORD_BITS-1:0]     r_off_y;
    logic        [1:0]                r_zoom;
    logic        [IMAGE_DIM_BITS-1:0] r_img_w;
    logic        [IMAGE_DIM_BITS-1:0] r_img_h;
    logic        [1:0]                r_mode;
    logic        [IMAGE_DIM_BITS-1:0] r_col;
    logic        [IMAGE_DIM_BITS-1:0] r_row;
    logic        [IMAGE_DIM_BITS-1:0] n_col;
    logic        [IMAGE_DIM_BITS-1:0] n_row;

    logic        [1:0]                z_sat;
    logic        [ZX_BITS-1:0]        zx;
    logic        [ZY_BITS-1:0]        zy;
    logic        [COORD_BITS-1:0]     dw_eff;
    logic        [COORD_BITS-1:0]     dw_half;
    logic        [COORD_BITS-1:0]     dh_half;
    logic        [IMAGE_DIM_BITS-1:0] iw_half;
    logic        [IMAGE_DIM_BITS-1:0] ih_half;
    logic signed [SW-1:0]             diff_x;
    logic signed [SW-1:0]             diff_y;
    logic signed [SW-1:0]             ox_raw;
    logic signed [SW-1:0]             oy_raw;
    logic signed [SW-1:0]             ox;
    logic signed [SW-1:0]             oy;
    logic        [IMAGE_DIM_BITS:0]   col_p1;
    logic        [IMAGE_DIM_BITS:0]   row_p1;
    logic signed [SW-1:0]             end_x;
    logic signed [SW-1:0]             end_y;
    logic signed [SW-1:0]             bx_full;
    logic signed [SW-1:0]             by_full;
    logic                             in_img;
    logic                             draw;
    logic                             accept;

    // Effective zoom and display width per adapter mode
    always_comb begin
        z_sat = (r_zoom > ZOOM_MAX) ? ZOOM_MAX : r_zoom;
        zy    = ZY_BITS'(z_sat);
        unique case (r_mode)
            MODE_MDA: begin
                zx     = ZX_BITS'(z_sat >> 1);
                dw_eff = r_disp_w >> 1;
            end
            MODE_LORES: begin
                zx     = ZX_BITS'(z_sat) << 1;
                dw_eff = r_disp_w;
            end
            default: begin
                zx     = ZX_BITS'(z_sat);
                dw_eff = r_disp_w;
            end
        endcase
    end

    // Centred origin, clamped at zero
    always_comb begin
        dw_half = dw_eff >> 1;
        dh_half = r_disp_h >> 1;
        iw_half = r_img_w >> 1;
        ih_half = r_img_h >> 1;
        diff_x  = SW'(r_off_x) - $signed(SW'(iw_half));
        diff_y  = SW'(r_off_y) - $signed(SW'(ih_half));
        ox_raw  = $signed(SW'(dw_half)) + (diff_x <<< zx);
        oy_raw  = $signed(SW'(dh_half)) + (diff_y <<< zy);
        ox      = ox_raw[SW-1] ? '0 : ox_raw;
        oy      = oy_raw[SW-1] ? '0 : oy_raw;
    end

    // Classify the pixel: inside the image and clear of the display edges
    always_comb begin
        col_p1  = {1'b0, r_col} + (IMAGE_DIM_BITS+1)'(1);
        row_p1  = {1'b0, r_row} + (IMAGE_DIM_BITS+1)'(1);
        end_x   = ox + ($signed(SW'(col_p1)) <<< zx);
        end_y   = oy + ($signed(SW'(row_p1)) <<< zy);
        bx_full = ox + ($signed(SW'(r_col)) <<< zx);
        by_full = oy + ($signed(SW'(r_row)) <<< zy);
        in_img  = (r_col < r_img_w) && (r_row < r_img_h);
        draw    = in_img && (end_x < $signed(SW'(dw_eff)))
                         && (end_y < $signed(SW'(r_disp_h)));
    end

    // Raster counters wrap after a full image
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (col_p1 >= {1'b0, r_img_w}) begin
            n_col = '0;
            if (row_p1 >= {1'b0, r_img_h}) begin
                n_row = '0;
            end else begin
                n_row = row_p1[IMAGE_DIM_BITS-1:0];
            end
        end else begin
            n_col = col_p1[IMAGE_DIM_BITS-1:0];
        end
    end

    assign accept    = i_push && !i_q_full;
    assign o_full    = i_q_full;
    assign o_q_push  = accept && draw;
    assign o_bx      = bx_full[COORD_BITS-1:0];
    assign o_by      = by_full[COORD_BITS-1:0];
    assign o_zoom.zx = zx;
    assign o_zoom.zy = zy;
    assign o_color   = i_pixel_color;

    // Configuration registers and raster counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disp_w <= COORD_BITS'(DISPLAY_WIDTH_RST);
            r_disp_h <= COORD_BITS'(DISPLAY_HEIGHT_RST);
            r_off_x  <= '0;
            r_off_y  <= '0;
            r_zoom   <= '0;
            r_img_w  <= IMAGE_DIM_BITS'(IMAGE_DIM_RST);
            r_img_h  <= IMAGE_DIM_BITS'(IMAGE_DIM_RST);
            r_mode   <= MODE_OTHER;
            r_col    <= '0;
            r_row    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_DISPLAY_WIDTH:  r_disp_w <= i_cfg_data[COORD_BITS-1:0];
                    REG_DISPLAY_HEIGHT: r_disp_h <= i_cfg_data[COORD_BITS-1:0];
                    REG_OFFSET_X:       r_off_x  <= $signed(i_cfg_data[COORD_BITS-1:0]);
                    REG_OFFSET_Y:       r_off_y  <= $signed(i_cfg_data[COORD_BITS-1:0]);
                    REG_ZOOM:           r_zoom   <= i_cfg_data[1:0];
                    REG_IMAGE_WIDTH:    r_img_w  <= i_cfg_data[IMAGE_DIM_BITS-1:0];
                    REG_IMAGE_HEIGHT:   r_img_h  <= i_cfg_data[IMAGE_DIM_BITS-1:0];
                    REG_ADAPTER_MODE:   r_mode   <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

endmodule

// ===== design/zsb_queue.sv =====
// Small job queue between the front and back ends.
module zsb_queue #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ===== design/zsb_back.sv =====
// Back end: expands one job into its block of frame-buffer writes.
module zsb_back #(
    parameter int COORD_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [COORD_BITS-1:0] i_job_x,
    input  logic [COORD_BITS-1:0] i_job_y,
    input  zsb_pkg::t_zoom        i_job_zoom,
    input  logic [7:0]            i_job_color,
    input  logic                  i_q_empty,
    output logic                  o_q_pop,
    input  logic                  i_pop,
    output logic                  o_empty,
    output logic [COORD_BITS-1:0] o_write_x,
    output logic [COORD_BITS-1:0] o_write_y,
    output logic [7:0]            o_write_color,
    output logic                  o_last_write
);
    import zsb_pkg::*;

    logic                  r_busy;
    logic [COORD_BITS-1:0] r_bx;
    logic [COORD_BITS-1:0] r_by;
    t_zoom                 r_zoom;
    logic [7:0]            r_color;
    logic [SX_BITS-1:0]    r_sx;
    logic [SY_BITS-1:0]    r_sy;
    logic                  r_out_valid;
    logic [COORD_BITS-1:0] r_wx;
    logic [COORD_BITS-1:0] r_wy;
    logic [7:0]            r_wc;
    logic                  r_wl;

    logic [SX_BITS-1:0]    sx_max;
    logic [SY_BITS-1:0]    sy_max;
    logic                  last;
    logic                  adv;
    logic                  load;

    // Sub-block limits and step control
    assign sx_max  = SX_BITS'((5'd1 << r_zoom.zx) - 5'd1);
    assign sy_max  = SY_BITS'((3'd1 << r_zoom.zy) - 3'd1);
    assign last    = (r_sx == sx_max) && (r_sy == sy_max);
    assign adv     = !r_out_valid || i_pop;
    assign load    = !i_q_empty && (!r_busy || (adv && last));
    assign o_q_pop = load;

    assign o_empty       = !r_out_valid;
    assign o_write_x     = r_wx;
    assign o_write_y     = r_wy;
    assign o_write_color = r_wc;
    assign o_last_write  = r_wl;

    // Walk SubX outer, SubY inner; output register decouples the consumer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_out_valid <= r_busy;
            end
            // a new job takes over as the last write of the old one leaves
            if (load) begin
                r_busy <= 1'b1;
            end else if (adv && r_busy && last) begin
                r_busy <= 1'b0;
            end
            if (adv && r_busy) begin
                r_wx <= r_bx + COORD_BITS'(r_sx);
                r_wy <= r_by + COORD_BITS'(r_sy);
                r_wc <= r_color;
                r_wl <= last;
                if (!last) begin
                    if (r_sy == sy_max) begin
                        r_sy <= '0;
                        r_sx <= r_sx + SX_BITS'(1);
                    end else begin
                        r_sy <= r_sy + SY_BITS'(1);
                    end
                end
            end
            if (load) begin
                r_bx    <= i_job_x;
                r_by    <= i_job_y;
                r_zoom  <= i_job_zoom;
                r_color <= i_job_color;
                r_sx    <= '0;
                r_sy    <= '0;
            end
        end
    end

endmodule

// ===== design/zoomed_sprite_blit.sv =====
// Zoomed sprite blitter top level: front end, job queue and write generator.
// Pixel colours enter in raster order, one transfer per cycle while full is low;
// each pixel becomes a 2^zx by 2^zy block of frame-buffer writes (x outer, y inner)
// around a centred origin, and pixels whose block would reach the display edge are
// dropped silently. The write generator issues one write per cycle while pop is
// high; a drawn pixel gives 2^zx * 2^zy writes (4 at zoom 1 in MODE_OTHER, 1 to 64
// overall); a dropped pixel costs nothing. The front end takes a pixel every cycle
// while the four-entry job queue has room, and full rises only when it is full.
// Configuration writes take effect at once and are meant for an idle block.
module zoomed_sprite_blit #(
    parameter int COORD_BITS     = 10,
    parameter int IMAGE_DIM_BITS = 8,
    localparam int CFG_W = (COORD_BITS > IMAGE_DIM_BITS) ? COORD_BITS : IMAGE_DIM_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [zsb_pkg::REG_IDX_BITS-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]                 i_cfg_data,
    input  logic                             push,
    output logic                             full,
    input  logic [7:0]                       i_pixel_color,
    output logic                             empty,
    input  logic                             pop,
    output logic [COORD_BITS-1:0]            o_write_x,
    output logic [COORD_BITS-1:0]            o_write_y,
    output logic [7:0]                       o_write_color,
    output logic                             o_last_write
);
    import zsb_pkg::*;

    localparam int JOB_W = 2 * COORD_BITS + ZOOM_BITS + 8;

    logic                  q_push;
    logic                  q_pop;
    logic                  q_full;
    logic                  q_empty;
    logic [JOB_W-1:0]      q_wr_data;
    logic [JOB_W-1:0]      q_rd_data;
    logic [COORD_BITS-1:0] f_bx;
    logic [COORD_BITS-1:0] f_by;
    t_zoom                 f_zoom;
    logic [7:0]            f_color;
    logic [COORD_BITS-1:0] b_x;
    logic [COORD_BITS-1:0] b_y;
    t_zoom                 b_zoom;
    logic [7:0]            b_color;

    // Pixel classification
    zsb_front #(
        .COORD_BITS     (COORD_BITS),
        .IMAGE_DIM_BITS (IMAGE_DIM_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .i_push        (push),
        .i_pixel_color (i_pixel_color),
        .i_q_full      (q_full),
        .o_full        (full),
        .o_q_push      (q_push),
        .o_bx          (f_bx),
        .o_by          (f_by),
        .o_zoom        (f_zoom),
        .o_color       (f_color)
    );

    // Job packing across the queue
    assign q_wr_data = {f_bx, f_by, f_zoom, f_color};
    assign b_color   = q_rd_data[7:0];
    assign b_zoom    = q_rd_data[8 +: ZOOM_BITS];
    assign b_y       = q_rd_data[8 + ZOOM_BITS +: COORD_BITS];
    assign b_x       = q_rd_data[8 + ZOOM_BITS + COORD_BITS +: COORD_BITS];

    zsb_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wr_data),
        .i_pop   (q_pop),
        .o_data  (q_rd_data),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // Write generation
    zsb_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_x       (b_x),
        .i_job_y       (b_y),
        .i_job_zoom    (b_zoom),
        .i_job_color   (b_color),
        .i_q_empty     (q_empty),
        .o_q_pop       (q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_write_x     (o_write_x),
        .o_write_y     (o_write_y),
        .o_write_color (o_write_color),
        .o_last_write  (o_last_write)
    );

endmodule

// ===== design/zsb_checker.sv =====
// Port-level checks for the zoomed sprite blitter, bound to the top level.
module zsb_checker #(
    parameter int COORD_BITS = 10
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  full,
    input logic                  empty,
    input logic                  pop,
    input logic [COORD_BITS-1:0] o_write_x,
    input logic [COORD_BITS-1:0] o_write_y,
    input logic [7:0]            o_write_color,
    input logic                  o_last_write
);

    // Reset leaves no result waiting
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result waiting after reset");

    // Reset leaves the queue with room
    a_reset_room: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("full after reset");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_write_x) && $stable(o_write_y)
                              && $stable(o_write_color) && $stable(o_last_write)))
        else $error("stalled result changed");

    // The rest of a pixel's block follows the previous write without a gap
    a_block_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_last_write) |=> !empty)
        else $error("gap inside a pixel block");

    // Writes within a block share the colour
    a_block_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_last_write) |=> (o_write_color == $past(o_write_color)))
        else $error("colour changed inside a pixel block");

endmodule

bind zoomed_sprite_blit zsb_checker #(.COORD_BITS(COORD_BITS)) u_checker (.*);
